// ===== sv/tun_pkg.sv =====
// Shared types, widths and constants for the triangle unit normal pipeline.
`default_nettype none
package tun_pkg;
	localparam int COORD_WIDTH = 16;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int EDGE_LIMIT_BITS = 30;
	localparam int NORM_TOP_BITS = 31;

	localparam int DW = COORD_WIDTH + 1;
	localparam int EMW = (DW > EDGE_LIMIT_BITS) ? EDGE_LIMIT_BITS : DW;
	localparam int ESW = EMW + 1;
	localparam int PW = 2 * ESW;
	localparam int KMW = 2 * EMW + 1;
	localparam int BLE = $clog2(DW + 1);
	localparam int BLK = $clog2(KMW + 1);
	localparam int NB = NORM_TOP_BITS;
	localparam int SW = 64;
	localparam int RW = 32;
	localparam int QW = NORMAL_FRAC_BITS + 1;
	localparam int OW = NORMAL_FRAC_BITS + 2;
	localparam int XW = RW + QW + 1;
	localparam int FRONT_STAGES = 7;
	localparam int ROOT_STAGES = 34;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] a_x;
		logic signed [COORD_WIDTH-1:0] a_y;
		logic signed [COORD_WIDTH-1:0] a_z;
		logic signed [COORD_WIDTH-1:0] b_x;
		logic signed [COORD_WIDTH-1:0] b_y;
		logic signed [COORD_WIDTH-1:0] b_z;
		logic signed [COORD_WIDTH-1:0] c_x;
		logic signed [COORD_WIDTH-1:0] c_y;
		logic signed [COORD_WIDTH-1:0] c_z;
	} tun_in_t;

	typedef struct packed {
		logic signed [OW-1:0] normal_x;
		logic signed [OW-1:0] normal_y;
		logic signed [OW-1:0] normal_z;
		logic degenerate;
	} tun_out_t;

	typedef struct packed {
		logic [2:0][NB-1:0] km;
		logic [2:0] neg;
		logic deg;
	} tun_norm_t;

	typedef struct packed {
		tun_norm_t nrm;
		logic [RW-1:0] root;
	} tun_root_t;

	typedef struct packed {
		logic [2:0][QW-1:0] quo;
		logic [2:0] neg;
		logic deg;
	} tun_quo_t;
endpackage
`default_nettype wire

// ===== sv/tun_front.sv =====
// Edge vectors, cross product and normalisation of the cross product magnitudes.
`default_nettype none
module tun_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic valid,
	input wire tun_pkg::tun_in_t vert,
	output logic nrm_valid,
	output tun_pkg::tun_norm_t nrm
);
	localparam int CW = tun_pkg::COORD_WIDTH;
	localparam int DW = tun_pkg::DW;
	localparam int EMW = tun_pkg::EMW;
	localparam int ESW = tun_pkg::ESW;
	localparam int PW = tun_pkg::PW;
	localparam int KMW = tun_pkg::KMW;
	localparam int BLE = tun_pkg::BLE;
	localparam int BLK = tun_pkg::BLK;
	localparam int NB = tun_pkg::NB;

	logic [tun_pkg::FRONT_STAGES:1] v_q;
	logic signed [DW-1:0] d_s1 [6];
	logic signed [ESW-1:0] e_s2 [6];
	logic signed [PW-1:0] p_s3 [6];
	logic signed [PW-1:0] k_s4 [3];
	logic [KMW-1:0] km_s5 [3];
	logic [2:0] neg_s5;
	logic deg_s5;
	logic [KMW-1:0] km_s6 [3];
	logic [2:0] neg_s6;
	logic deg_s6;
	logic [BLK-1:0] bl_s6;
	tun_pkg::tun_norm_t nrm_s7;

	logic [DW-1:0] emag [6];
	logic [DW-1:0] eor;
	logic [BLE-1:0] ebl;
	logic [BLE-1:0] esh;
	logic [KMW-1:0] kor;
	logic [BLK-1:0] kbl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[tun_pkg::FRONT_STAGES-1:1], valid};
		end
	end

	always_comb begin
		eor = '0;
		for (int i = 0; i < 6; i++) begin
			emag[i] = d_s1[i][DW-1] ? DW'(-d_s1[i]) : DW'(d_s1[i]);
			eor = eor | emag[i];
		end
		ebl = '0;
		for (int b = 0; b < DW; b++) begin
			if (eor[b]) ebl = BLE'(b + 1);
		end
		esh = (ebl > BLE'(EMW)) ? ebl - BLE'(EMW) : '0;
	end

	always_comb begin
		kor = km_s5[0] | km_s5[1] | km_s5[2];
		kbl = '0;
		for (int b = 0; b < KMW; b++) begin
			if (kor[b]) kbl = BLK'(b + 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= DW'($signed(vert.a_x[CW-1:0])) - DW'($signed(vert.b_x[CW-1:0]));
			d_s1[1] <= DW'($signed(vert.a_y[CW-1:0])) - DW'($signed(vert.b_y[CW-1:0]));
			d_s1[2] <= DW'($signed(vert.a_z[CW-1:0])) - DW'($signed(vert.b_z[CW-1:0]));
			d_s1[3] <= DW'($signed(vert.b_x[CW-1:0])) - DW'($signed(vert.c_x[CW-1:0]));
			d_s1[4] <= DW'($signed(vert.b_y[CW-1:0])) - DW'($signed(vert.c_y[CW-1:0]));
			d_s1[5] <= DW'($signed(vert.b_z[CW-1:0])) - DW'($signed(vert.c_z[CW-1:0]));
			for (int i = 0; i < 6; i++) begin
				if (d_s1[i][DW-1]) begin
					e_s2[i] <= -$signed({1'b0, EMW'(emag[i] >> esh)});
				end else begin
					e_s2[i] <= $signed({1'b0, EMW'(emag[i] >> esh)});
				end
			end
			p_s3[0] <= e_s2[1] * e_s2[5];
			p_s3[1] <= e_s2[2] * e_s2[4];
			p_s3[2] <= e_s2[2] * e_s2[3];
			p_s3[3] <= e_s2[0] * e_s2[5];
			p_s3[4] <= e_s2[0] * e_s2[4];
			p_s3[5] <= e_s2[1] * e_s2[3];
			k_s4[0] <= p_s3[0] - p_s3[1];
			k_s4[1] <= p_s3[2] - p_s3[3];
			k_s4[2] <= p_s3[4] - p_s3[5];
			for (int i = 0; i < 3; i++) begin
				neg_s5[i] <= k_s4[i][PW-1];
				km_s5[i] <= k_s4[i][PW-1] ? KMW'(-k_s4[i]) : KMW'(k_s4[i]);
			end
			deg_s5 <= (k_s4[0] == '0) && (k_s4[1] == '0) && (k_s4[2] == '0);
			km_s6 <= km_s5;
			neg_s6 <= neg_s5;
			deg_s6 <= deg_s5;
			bl_s6 <= kbl;
			for (int i = 0; i < 3; i++) begin
				nrm_s7.km[i] <= NB'({km_s6[i], {NB{1'b0}}} >> bl_s6);
			end
			nrm_s7.neg <= neg_s6;
			nrm_s7.deg <= deg_s6;
		end
	end

	assign nrm_valid = v_q[tun_pkg::FRONT_STAGES];
	assign nrm = nrm_s7;
endmodule
`default_nettype wire

// ===== sv/tun_root.sv =====
// Sum of squares and a one-bit-per-stage square root pipeline.
`default_nettype none
module tun_root (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic valid,
	input wire tun_pkg::tun_norm_t nrm,
	output logic root_valid,
	output tun_pkg::tun_root_t root
);
	localparam int NB = tun_pkg::NB;
	localparam int SW = tun_pkg::SW;
	localparam int RW = tun_pkg::RW;
	localparam int STEPS = RW;

	logic [tun_pkg::ROOT_STAGES:1] v_q;
	logic [2*NB-1:0] sq_s1 [3];
	tun_pkg::tun_norm_t nrm_s1;
	logic [SW-1:0] rv_s [STEPS+1];
	logic [SW-1:0] rr_s [STEPS+1];
	tun_pkg::tun_norm_t nrm_s [STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[tun_pkg::ROOT_STAGES-1:1], valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= (2*NB)'(nrm.km[i]) * (2*NB)'(nrm.km[i]);
			end
			nrm_s1 <= nrm;
			rv_s[0] <= SW'(sq_s1[0]) + SW'(sq_s1[1]) + SW'(sq_s1[2]);
			rr_s[0] <= '0;
			nrm_s[0] <= nrm_s1;
		end
	end

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * j);
		logic [SW-1:0] trial;
		assign trial = rr_s[j] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rv_s[j] >= trial) begin
					rv_s[j+1] <= rv_s[j] - trial;
					rr_s[j+1] <= (rr_s[j] >> 1) + BIT;
				end else begin
					rv_s[j+1] <= rv_s[j];
					rr_s[j+1] <= rr_s[j] >> 1;
				end
				nrm_s[j+1] <= nrm_s[j];
			end
		end
	end

	assign root_valid = v_q[tun_pkg::ROOT_STAGES];
	assign root.nrm = nrm_s[STEPS];
	assign root.root = rr_s[STEPS][RW-1:0];
endmodule
`default_nettype wire

// ===== sv/tun_div.sv =====
// Rounded division of each magnitude by the length, one quotient bit per stage.
`default_nettype none
module tun_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic valid,
	input wire tun_pkg::tun_root_t root,
	output logic quo_valid,
	output tun_pkg::tun_quo_t quo
);
	localparam int NFB = tun_pkg::NORMAL_FRAC_BITS;
	localparam int QW = tun_pkg::QW;
	localparam int XW = tun_pkg::XW;
	localparam int RW = tun_pkg::RW;

	logic [QW:0] v_q;
	logic [XW-1:0] rem_s [QW+1][3];
	logic [QW-1:0] q_s [QW+1][3];
	logic [RW-1:0] l_s [QW+1];
	logic [2:0] neg_s [QW+1];
	logic deg_s [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[QW-1:0], valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rem_s[0][i] <= XW'({root.nrm.km[i], {NFB{1'b0}}}) + XW'(root.root >> 1);
				q_s[0][i] <= '0;
			end
			l_s[0] <= root.root;
			neg_s[0] <= root.nrm.neg;
			deg_s[0] <= root.nrm.deg;
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_bit
		localparam int SH = QW - 1 - j;
		logic [XW-1:0] dv;
		assign dv = XW'(l_s[j]) << SH;
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (rem_s[j][i] >= dv) begin
						rem_s[j+1][i] <= rem_s[j][i] - dv;
						q_s[j+1][i] <= q_s[j][i] | (QW'(1) << SH);
					end else begin
						rem_s[j+1][i] <= rem_s[j][i];
						q_s[j+1][i] <= q_s[j][i];
					end
				end
				l_s[j+1] <= l_s[j];
				neg_s[j+1] <= neg_s[j];
				deg_s[j+1] <= deg_s[j];
			end
		end
	end

	assign quo_valid = v_q[QW];
	assign quo.quo[0] = q_s[QW][0];
	assign quo.quo[1] = q_s[QW][1];
	assign quo.quo[2] = q_s[QW][2];
	assign quo.neg = neg_s[QW];
	assign quo.deg = deg_s[QW];
endmodule
`default_nettype wire

// ===== sv/triangle_unit_normal_unit.sv =====
// Top level of the triangle unit normal pipeline.
// Each transfer on the vert channel carries one triangle as three vertices
// of signed coordinates. Each transfer on the norm channel carries its unit
// normal as three signed Q1.14 components and a degenerate flag, which is set
// with zero components when the triangle has no area.
// Both channels transfer when valid is high and stall is low.
// One triangle is taken in every cycle while vert_stall is low; the block is fully pipelined.
// The pipeline stages are edges, cross product and normalisation, then the sum
// of squares and the square root, one bit per stage, then the rounded division,
// one quotient bit per stage, and last the output register.
// Results leave in the order the triangles arrived.
// Reset clears every valid bit, so the pipeline starts empty.
// While norm_stall holds back a waiting result the whole pipeline holds,
// vert_stall is raised and nothing is lost or repeated; an empty output
// register lets the pipeline move on.
`default_nettype none
module triangle_unit_normal_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic vert_valid,
	output logic vert_stall,
	input wire tun_pkg::tun_in_t vert,
	output logic norm_valid,
	input wire logic norm_stall,
	output tun_pkg::tun_out_t norm
);
	localparam int OW = tun_pkg::OW;

	logic en;
	logic nrm_valid;
	tun_pkg::tun_norm_t nrm;
	logic root_valid;
	tun_pkg::tun_root_t root;
	logic quo_valid;
	tun_pkg::tun_quo_t quo;
	logic out_valid_q;
	tun_pkg::tun_out_t out_q;
	logic signed [OW-1:0] comp [3];

	assign en = !(out_valid_q && norm_stall);
	assign vert_stall = !en;

	tun_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .valid(vert_valid), .vert(vert),
		.nrm_valid(nrm_valid), .nrm(nrm)
	);

	tun_root u_root (
		.clk(clk), .arst_n(arst_n), .en(en), .valid(nrm_valid), .nrm(nrm),
		.root_valid(root_valid), .root(root)
	);

	tun_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .valid(root_valid), .root(root),
		.quo_valid(quo_valid), .quo(quo)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (quo.deg) begin
				comp[i] = '0;
			end else if (quo.neg[i]) begin
				comp[i] = -$signed({1'b0, quo.quo[i]});
			end else begin
				comp[i] = $signed({1'b0, quo.quo[i]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= quo_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.normal_x <= comp[0];
			out_q.normal_y <= comp[1];
			out_q.normal_z <= comp[2];
			out_q.degenerate <= quo.deg;
		end
	end

	assign norm_valid = out_valid_q;
	assign norm = out_q;
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the triangle unit normal pipeline.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic vert_valid = 1'b0;
	logic vert_stall;
	tun_pkg::tun_in_t vert = '0;
	logic norm_valid;
	logic norm_stall = 1'b0;
	tun_pkg::tun_out_t norm;

	tun_pkg::tun_in_t tri_queue[$];
	tun_pkg::tun_out_t normal_queue[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;
	bit sender_pause = 1'b0;
	bit vert_taken = 1'b0;
	int mismatches = 0;

	triangle_unit_normal_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.vert_valid(vert_valid), .vert_stall(vert_stall), .vert(vert),
		.norm_valid(norm_valid), .norm_stall(norm_stall), .norm(norm)
	);

	always #4 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= r + bitv) begin
				v -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		return r;
	endfunction

	function automatic tun_pkg::tun_out_t unit_normal(tun_pkg::tun_in_t t);
		longint edge_v[6];
		longint cross_v[3];
		longint unsigned mag[3];
		longint unsigned top;
		longint unsigned sq;
		longint unsigned len;
		longint unsigned q;
		logic [tun_pkg::OW-1:0] comp[3];
		int nb;
		tun_pkg::tun_out_t r;
		edge_v[0] = longint'(t.a_x) - longint'(t.b_x);
		edge_v[1] = longint'(t.a_y) - longint'(t.b_y);
		edge_v[2] = longint'(t.a_z) - longint'(t.b_z);
		edge_v[3] = longint'(t.b_x) - longint'(t.c_x);
		edge_v[4] = longint'(t.b_y) - longint'(t.c_y);
		edge_v[5] = longint'(t.b_z) - longint'(t.c_z);
		cross_v[0] = edge_v[1] * edge_v[5] - edge_v[2] * edge_v[4];
		cross_v[1] = edge_v[2] * edge_v[3] - edge_v[0] * edge_v[5];
		cross_v[2] = edge_v[0] * edge_v[4] - edge_v[1] * edge_v[3];
		r = '0;
		top = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = cross_v[i] < 0 ? -cross_v[i] : cross_v[i];
			if (mag[i] > top) top = mag[i];
		end
		if (top == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		nb = 0;
		while ((top >> nb) != 0) nb++;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			if (nb > tun_pkg::NORM_TOP_BITS) mag[i] >>= (nb - tun_pkg::NORM_TOP_BITS);
			else mag[i] <<= (tun_pkg::NORM_TOP_BITS - nb);
			sq += mag[i] * mag[i];
		end
		len = int_sqrt(sq);
		for (int i = 0; i < 3; i++) begin
			q = ((mag[i] << tun_pkg::NORMAL_FRAC_BITS) + (len >> 1)) / len;
			comp[i] = cross_v[i] < 0 ? tun_pkg::OW'(-q) : tun_pkg::OW'(q);
		end
		r.normal_x = comp[0];
		r.normal_y = comp[1];
		r.normal_z = comp[2];
		return r;
	endfunction

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(0, 15)) - 16'd8;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic tun_pkg::tun_in_t random_triangle();
		tun_pkg::tun_in_t t;
		t = tun_pkg::tun_in_t'($bits(tun_pkg::tun_in_t)'({$urandom, $urandom, $urandom,
			$urandom, $urandom}));
		case ($urandom_range(0, 9))
			0: begin
				t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z;
			end
			1: begin
				t.c_x = t.b_x + (t.b_x - t.a_x);
				t.c_y = t.b_y + (t.b_y - t.a_y);
				t.c_z = t.b_z + (t.b_z - t.a_z);
			end
			2: begin
				t.a_x = rand_coord(); t.a_y = rand_coord(); t.a_z = rand_coord();
				t.b_x = rand_coord(); t.b_y = rand_coord(); t.b_z = rand_coord();
				t.c_x = rand_coord(); t.c_y = rand_coord(); t.c_z = rand_coord();
			end
			3: begin
				t.b_x = t.a_x + 16'($urandom_range(0, 6)) - 16'd3;
				t.b_y = t.a_y + 16'($urandom_range(0, 6)) - 16'd3;
				t.b_z = t.a_z + 16'($urandom_range(0, 6)) - 16'd3;
				t.c_x = t.a_x + 16'($urandom_range(0, 6)) - 16'd3;
				t.c_y = t.a_y + 16'($urandom_range(0, 6)) - 16'd3;
				t.c_z = t.a_z + 16'($urandom_range(0, 6)) - 16'd3;
			end
			default: ;
		endcase
		return t;
	endfunction

	task automatic add_triangle(input logic [15:0] ax, ay, az, bx, by, bz, cx, cy, cz);
		tun_pkg::tun_in_t t;
		t.a_x = ax; t.a_y = ay; t.a_z = az;
		t.b_x = bx; t.b_y = by; t.b_z = bz;
		t.c_x = cx; t.c_y = cy; t.c_z = cz;
		tri_queue.push_back(t);
	endtask

	task automatic wait_drained();
		while (tri_queue.size() != 0 || vert_valid || normal_queue.size() != 0)
			@(posedge clk);
	endtask

	// Driver: offers the next pending triangle at the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!vert_valid || vert_taken) begin
				if (!sender_pause && tri_queue.size() != 0 &&
						$urandom_range(0, 99) >= send_idle_pct) begin
					vert <= tri_queue.pop_front();
					vert_valid <= 1'b1;
				end else begin
					vert_valid <= 1'b0;
				end
			end
			if (hold_cycles > 0) begin
				norm_stall <= 1'b1;
				hold_cycles <= hold_cycles - 1;
			end else begin
				norm_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	// Monitor: predicts on each vert transfer and checks each norm transfer.
	always @(posedge clk) begin
		tun_pkg::tun_out_t want;
		vert_taken <= arst_n && vert_valid && !vert_stall;
		if (arst_n) begin
			if (vert_valid && !vert_stall)
				normal_queue.push_back(unit_normal(vert));
			if (norm_valid && !norm_stall) begin
				if (normal_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected transfer on norm: %p", norm);
				end else begin
					want = normal_queue.pop_front();
					if (norm !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Normal mismatch: expected %p, got %p", want, norm);
					end
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_triangle(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
			16'h7fff, 16'h7fff, 16'h7fff);
		add_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0);
		add_triangle(0, 0, 0, 0, 1, 0, 1, 0, 0);
		add_triangle(0, 0, 0, 0, 0, 1, 1, 0, 0);
		add_triangle(0, 0, 0, 1, 1, 1, 2, 2, 2);
		add_triangle(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
			16'h8000, 16'h7fff, 16'h8000);
		add_triangle(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
			16'h7fff, 16'h7fff, 16'h8000);
		add_triangle(16'h8000, 0, 0, 16'h7fff, 0, 0, 0, 16'h7fff, 16'h8000);
		add_triangle(16'hffff, 16'hffff, 16'hffff, 0, 0, 0, 16'h7fff, 16'h8000, 1);
		add_triangle(1, 2, 3, 4, 5, 6, 7, 8, 10);
		add_triangle(16'h5555, 16'haaaa, 16'h1234, 16'hedcb, 16'h0f0f, 16'hf0f0,
			16'h8001, 16'h7ffe, 0);
		add_triangle(3, 3, 3, 3, 3, 3, 9, 1, 16'hfff0);

		send_idle_pct = 36;
		recv_idle_pct = 76;
		repeat (350) tri_queue.push_back(random_triangle());
		wait_drained();

		// Long hold-off on the result side while triangles keep coming.
		hold_cycles <= 200;
		repeat (150) tri_queue.push_back(random_triangle());
		wait_drained();

		send_idle_pct = 76;
		recv_idle_pct = 36;
		repeat (250) tri_queue.push_back(random_triangle());
		while (tri_queue.size() > 125) @(posedge clk);
		sender_pause = 1'b1;
		while (vert_valid || normal_queue.size() != 0) @(posedge clk);
		sender_pause = 1'b0;
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (350) tri_queue.push_back(random_triangle());
		wait_drained();
		repeat (100) @(posedge clk);

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
